// ===== design/ramped_step_pulse_generator_macros.svh =====
// Assertion macros shared by the step pulse generator modules.
`ifndef RAMPED_STEP_PULSE_GENERATOR_MACROS_SVH
`define RAMPED_STEP_PULSE_GENERATOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RSPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define RSPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/rspg_pkg.sv =====
// Types and constants of the ramped step pulse generator.
`timescale 1ns / 1ps

package rspg_pkg;

  // Ramp table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int HZ_W    = 16;
  localparam int CNT_W   = 16;
  localparam int LEN_W   = 11;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 2;

  // Timer base clock and the serial divider built around it.
  localparam int BASE_CLOCK_HZ = 72000000;
  localparam int NUM_W         = $clog2(BASE_CLOCK_HZ + 1);
  localparam int PROD_W        = 2 * HZ_W;
  localparam int STEP_W        = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_PRESCALER = 2'd0,
    CFG_START_HZ  = 2'd1,
    CFG_RAMP_LEN  = 2'd2,
    CFG_STOP_CNT  = 2'd3
  } cfg_e;

  typedef struct packed {
    op_e               opcode;
    logic [TABLE_AW-1:0] table_index;
    logic [HZ_W-1:0]   table_hz;
  } in_item_t;

  typedef struct packed {
    logic              pulse_level;
    logic              step_event;
    logic              running;
    logic [CNT_W-1:0]  step_count;
    logic [CNT_W-1:0]  period_counts;
  } out_item_t;

  // Request to the period divider.
  typedef struct packed {
    logic              start;
    logic [HZ_W-1:0]   hz;
    logic [HZ_W-1:0]   prescaler;
  } div_req_t;

  // Answer of the period divider.
  typedef struct packed {
    logic              done;
    logic [CNT_W-1:0]  period;
  } div_rsp_t;

endpackage

// ===== design/rspg_ramp_table.sv =====
// Ramp frequency table: one write port and one registered read port.
`timescale 1ns / 1ps

module rspg_ramp_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rspg_pkg::TABLE_AW-1:0] waddr_i,
  input  logic [rspg_pkg::HZ_W-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [rspg_pkg::TABLE_AW-1:0] raddr_i,
  output logic [rspg_pkg::HZ_W-1:0]     rdata_o
);

  logic [rspg_pkg::HZ_W-1:0] mem_q [rspg_pkg::TABLE_DEPTH];
  logic [rspg_pkg::HZ_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rspg_rate_div.sv =====
// Period divider: base clock over prescaler times frequency, one quotient bit a cycle.
`timescale 1ns / 1ps
`include "ramped_step_pulse_generator_macros.svh"

module rspg_rate_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rspg_pkg::div_req_t req_i,
  output rspg_pkg::div_rsp_t rsp_o
);

  logic [rspg_pkg::PROD_W-1:0] prod_q;
  logic [rspg_pkg::NUM_W-1:0]  num_q;
  logic [rspg_pkg::NUM_W-1:0]  rem_q;
  logic [rspg_pkg::CNT_W-1:0]  quot_q;
  logic                        ovf_q;
  logic [rspg_pkg::STEP_W-1:0] bits_q;
  logic                        run_q;
  logic                        done_q;

  logic [rspg_pkg::HZ_W-1:0]   div_eff;
  logic [rspg_pkg::NUM_W:0]    trial;
  logic [rspg_pkg::PROD_W-1:0] trial_ext;
  logic                        fits;
  logic [rspg_pkg::PROD_W-1:0] diff;

  // A zero prescaler counts as one.
  assign div_eff = (req_i.prescaler == '0) ? rspg_pkg::HZ_W'(1) : req_i.prescaler;

  // One restoring step: bring down the next dividend bit and try the subtract.
  // A zero frequency gives a zero divisor, so every bit fits and the result
  // saturates to the maximum period.
  assign trial     = {rem_q, num_q[rspg_pkg::NUM_W-1]};
  assign trial_ext = rspg_pkg::PROD_W'(trial);
  assign fits      = (trial_ext >= prod_q);
  assign diff      = trial_ext - prod_q;

  // Control: run flag and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
      end else if (run_q && (bits_q == rspg_pkg::STEP_W'(1))) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: divisor product, dividend shifter, remainder and quotient shifter.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= rspg_pkg::PROD_W'(req_i.hz) * rspg_pkg::PROD_W'(div_eff);
      num_q  <= rspg_pkg::NUM_W'(rspg_pkg::BASE_CLOCK_HZ);
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
      bits_q <= rspg_pkg::STEP_W'(rspg_pkg::NUM_W);
    end else if (run_q) begin
      rem_q  <= fits ? diff[rspg_pkg::NUM_W-1:0] : trial[rspg_pkg::NUM_W-1:0];
      quot_q <= {quot_q[rspg_pkg::CNT_W-2:0], fits};
      ovf_q  <= ovf_q | quot_q[rspg_pkg::CNT_W-1];
      num_q  <= {num_q[rspg_pkg::NUM_W-2:0], 1'b0};
      bits_q <= bits_q - rspg_pkg::STEP_W'(1);
    end
  end

  // Quotients beyond 16 bits saturate.
  assign rsp_o.done   = done_q;
  assign rsp_o.period = ovf_q ? '1 : quot_q;

  `RSPG_ASSERT(a_div_start_idle, clk_i, rst_ni, req_i.start |-> !run_q, "divider restarted while busy")
  `RSPG_ASSERT(a_div_last_step, clk_i, rst_ni, (run_q && (bits_q == rspg_pkg::STEP_W'(1)) && !req_i.start) |=> (done_q && !run_q), "divider missed its completion")

endmodule

// ===== design/ramped_step_pulse_generator.sv =====
// Top level of the ramped step pulse generator: tick engine, control and result register.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   in       | input     | in_valid_i / in_ready_o   | in_item_i  (rspg_pkg::in_item_t)
//   out      | output    | out_valid_o / out_ready_i | out_item_o (rspg_pkg::out_item_t)
//   cfg      | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// Tick, stop and load items load the result register at accept.
// A start item forms the divisor product at accept, then the divider takes one restoring step per
// dividend bit, ST_RATE takes the quotient and ST_RESP loads the result register once it is free.
// A tick that reloads the period from the ramp table first reads the table in ST_READ.
// One item is in work at a time; a finished item waits in the output register.
// Reset clears control state and loads the register defaults; the ramp table is not cleared.
`timescale 1ns / 1ps
`include "ramped_step_pulse_generator_macros.svh"

module ramped_step_pulse_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rspg_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rspg_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [rspg_pkg::CFG_AW-1:0]    cfg_index_i,
  input  logic [rspg_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_RATE = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e                         state_q, state_d;

  // Configuration registers.
  logic [rspg_pkg::HZ_W-1:0]      presc_q;
  logic [rspg_pkg::HZ_W-1:0]      start_hz_q;
  logic [rspg_pkg::LEN_W-1:0]     ramp_len_q;
  logic [rspg_pkg::CNT_W-1:0]     stop_cnt_q;

  // Generator state.
  logic [rspg_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [rspg_pkg::CNT_W-1:0]     period_q, period_d;
  logic [rspg_pkg::CNT_W-1:0]     cmp_q, cmp_d;
  logic [rspg_pkg::CNT_W-1:0]     steps_q, steps_d;
  logic                           en_q, en_d;
  logic                           event_q, event_d;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  rspg_pkg::out_item_t            out_item_q, out_item_d;

  logic                           accept;
  logic                           slot_free;
  logic [rspg_pkg::CNT_W-1:0]     cnt_next;
  logic [rspg_pkg::CNT_W-1:0]     steps_inc;
  logic [rspg_pkg::LEN_W-1:0]     len_clamp;
  logic                           hit;
  logic                           need_load;
  logic                           slow;
  logic [rspg_pkg::HZ_W-1:0]      table_rdata;
  rspg_pkg::div_req_t             div_req;
  rspg_pkg::div_rsp_t             div_rsp;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q    <= rspg_pkg::HZ_W'(72);
      start_hz_q <= rspg_pkg::HZ_W'(100);
      ramp_len_q <= rspg_pkg::LEN_W'(1024);
      stop_cnt_q <= rspg_pkg::CNT_W'(8000);
    end else if (cfg_we_i) begin
      case (rspg_pkg::cfg_e'(cfg_index_i))
        rspg_pkg::CFG_PRESCALER: presc_q    <= cfg_data_i;
        rspg_pkg::CFG_START_HZ:  start_hz_q <= cfg_data_i;
        rspg_pkg::CFG_RAMP_LEN:  ramp_len_q <= cfg_data_i[rspg_pkg::LEN_W-1:0];
        rspg_pkg::CFG_STOP_CNT:  stop_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick arithmetic: counter wrap, compare match, saturating step count.
  assign cnt_next  = (cnt_q >= period_q) ? '0 : cnt_q + rspg_pkg::CNT_W'(1);
  assign hit       = en_q && (cnt_next == cmp_q);
  assign steps_inc = (steps_q != '1) ? steps_q + rspg_pkg::CNT_W'(1) : steps_q;
  assign len_clamp = (ramp_len_q > rspg_pkg::LEN_W'(rspg_pkg::TABLE_DEPTH))
                     ? rspg_pkg::LEN_W'(rspg_pkg::TABLE_DEPTH) : ramp_len_q;
  assign need_load = (({1'b0, steps_inc} + (rspg_pkg::CNT_W + 1)'(1))
                      < (rspg_pkg::CNT_W + 1)'(len_clamp));
  assign slow      = (in_item_i.opcode == rspg_pkg::OP_START) ||
                     ((in_item_i.opcode == rspg_pkg::OP_TICK) && hit && need_load);

  // Next state of the generator and of the control sequence.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    steps_d  = steps_q;
    en_d     = en_q;
    event_d  = event_q;
    period_d = period_q;
    cmp_d    = cmp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            rspg_pkg::OP_TICK: begin
              if (en_q) begin
                cnt_d = cnt_next;
              end
              if (hit) begin
                steps_d = steps_inc;
                if (steps_inc == stop_cnt_q) begin
                  en_d = 1'b0;
                end
              end
              event_d = hit;
            end
            rspg_pkg::OP_START: begin
              cnt_d   = '0;
              steps_d = '0;
              en_d    = 1'b1;
              event_d = 1'b0;
            end
            rspg_pkg::OP_STOP: begin
              en_d    = 1'b0;
              event_d = 1'b0;
            end
            default: begin
              event_d = 1'b0;
            end
          endcase
          if (slow) begin
            state_d = (in_item_i.opcode == rspg_pkg::OP_START) ? ST_RATE : ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_RATE;
      end
      ST_RATE: begin
        if (div_rsp.done) begin
          period_d = div_rsp.period;
          cmp_d    = div_rsp.period >> 1;
          state_d  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register loading: fast items at accept, slow items after the divider.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (accept && !slow) begin
      out_valid_d              = 1'b1;
      out_item_d.pulse_level   = en_d && (cnt_d >= cmp_q);
      out_item_d.step_event    = event_d;
      out_item_d.running       = en_d;
      out_item_d.step_count    = steps_d;
      out_item_d.period_counts = period_q;
    end else if ((state_q == ST_RESP) && slot_free) begin
      out_valid_d              = 1'b1;
      out_item_d.pulse_level   = en_q && (cnt_q >= cmp_q);
      out_item_d.step_event    = event_q;
      out_item_d.running       = en_q;
      out_item_d.step_count    = steps_q;
      out_item_d.period_counts = period_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      period_q    <= '0;
      cmp_q       <= '0;
      steps_q     <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      period_q    <= period_d;
      cmp_q       <= cmp_d;
      steps_q     <= steps_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    event_q    <= event_d;
    out_item_q <= out_item_d;
  end

  // Ramp table: load items write, a reloading tick reads the entry of the new count.
  rspg_ramp_table u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (in_item_i.opcode == rspg_pkg::OP_LOAD)),
    .waddr_i (in_item_i.table_index),
    .wdata_i (in_item_i.table_hz),
    .re_i    (accept),
    .raddr_i (steps_inc[rspg_pkg::TABLE_AW-1:0]),
    .rdata_o (table_rdata)
  );

  // Period divider, started by a start item or after the table read.
  assign div_req.start     = (accept && (in_item_i.opcode == rspg_pkg::OP_START)) ||
                             (state_q == ST_READ);
  assign div_req.hz        = (state_q == ST_READ) ? table_rdata : start_hz_q;
  assign div_req.prescaler = presc_q;

  rspg_rate_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `RSPG_ASSERT_NEVER(a_done_outside_rate, clk_i, rst_ni, div_rsp.done && (state_q != ST_RATE), "divider finished while no rate was pending")
  `RSPG_ASSERT(a_compare_in_period, clk_i, rst_ni, cmp_q <= period_q, "compare value above period")
  `RSPG_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)), "result item changed while waiting")

endmodule

// ===== bench/ramped_step_pulse_generator_test.sv =====
// Self-checking testbench of the ramped step pulse generator with a cycle-free prediction model.
`timescale 1ns / 1ps

module ramped_step_pulse_generator_test;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 40;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  rspg_pkg::in_item_t            in_item_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  rspg_pkg::out_item_t           out_item_o;
  logic                          cfg_we_i = 1'b0;
  logic [rspg_pkg::CFG_AW-1:0]   cfg_index_i = '0;
  logic [rspg_pkg::CFG_W-1:0]    cfg_data_i = '0;

  ramped_step_pulse_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Commands waiting to be sent and pulse states predicted for accepted commands.
  rspg_pkg::in_item_t    pending_commands[$];
  rspg_pkg::out_item_t   predicted_pulses[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // Register copies and generator state of the prediction model.
  logic [15:0] reg_prescaler = 16'd72;
  logic [15:0] reg_start_hz = 16'd100;
  logic [10:0] reg_ramp_len = 11'd1024;
  logic [15:0] reg_stop_count = 16'd8000;
  logic [15:0] gen_counter = '0;
  logic [15:0] gen_period = '0;
  logic [15:0] gen_compare = '0;
  logic [15:0] gen_steps = '0;
  logic        gen_running = 1'b0;
  logic [15:0] gen_table [rspg_pkg::TABLE_DEPTH];
  bit          entry_loaded [rspg_pkg::TABLE_DEPTH];

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Period and compare value for a step rate, saturated to 16 bits.
  function automatic void apply_rate(logic [15:0] hz);
    int unsigned div;
    int unsigned p;
    div = (reg_prescaler == 16'd0) ? 1 : int'(reg_prescaler);
    if (hz == 16'd0) begin
      p = 65535;
    end else begin
      p = rspg_pkg::BASE_CLOCK_HZ / div / int'(hz);
      if (p > 65535) p = 65535;
    end
    gen_period  = p[15:0];
    gen_compare = p[16:1];
  endfunction

  // Advance the generator by one command and return the pulse state it leaves.
  function automatic rspg_pkg::out_item_t advance_generator(rspg_pkg::in_item_t cmd);
    rspg_pkg::out_item_t res;
    int unsigned         span;
    logic                hit;
    hit = 1'b0;
    case (cmd.opcode)
      rspg_pkg::OP_TICK: begin
        if (gen_running) begin
          if (gen_counter >= gen_period) gen_counter = '0;
          else gen_counter = gen_counter + 16'd1;
          if (gen_counter == gen_compare) begin
            hit = 1'b1;
            span = (reg_ramp_len > rspg_pkg::TABLE_DEPTH) ? rspg_pkg::TABLE_DEPTH
                                                          : int'(reg_ramp_len);
            if (gen_steps != 16'hFFFF) gen_steps = gen_steps + 16'd1;
            if (int'(gen_steps) + 1 < span)
              apply_rate(gen_table[gen_steps[rspg_pkg::TABLE_AW-1:0]]);
            if (gen_steps == reg_stop_count) gen_running = 1'b0;
          end
        end
      end
      rspg_pkg::OP_START: begin
        gen_counter = '0;
        gen_steps   = '0;
        apply_rate(reg_start_hz);
        gen_running = 1'b1;
      end
      rspg_pkg::OP_STOP: begin
        gen_running = 1'b0;
      end
      default: begin
        gen_table[cmd.table_index] = cmd.table_hz;
      end
    endcase
    res.pulse_level   = gen_running && (gen_counter >= gen_compare);
    res.step_event    = hit;
    res.running       = gen_running;
    res.step_count    = gen_steps;
    res.period_counts = gen_period;
    return res;
  endfunction

  function automatic bit roll_pct(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Command driver: presents queued commands and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    logic took;
    took = 1'b0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_pulses.push_back(advance_generator(pending_commands.pop_front()));
        took = 1'b1;
      end
      if (!in_valid_i || took) begin
        if (pending_commands.size() != 0 && !roll_pct(sender_idle_pct)) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_commands[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted pulse state with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    rspg_pkg::out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_pulses.size() == 0) begin
          $error("result item with no prediction waiting");
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = predicted_pulses.pop_front();
          if (out_item_o !== want) mismatch_count <= mismatch_count + 1;
          if (out_item_o.pulse_level !== want.pulse_level)
            $error("pulse_level: expected %0d, actual %0d",
                   want.pulse_level, out_item_o.pulse_level);
          if (out_item_o.step_event !== want.step_event)
            $error("step_event: expected %0d, actual %0d",
                   want.step_event, out_item_o.step_event);
          if (out_item_o.running !== want.running)
            $error("running: expected %0d, actual %0d", want.running, out_item_o.running);
          if (out_item_o.step_count !== want.step_count)
            $error("step_count: expected %0d, actual %0d",
                   want.step_count, out_item_o.step_count);
          if (out_item_o.period_counts !== want.period_counts)
            $error("period_counts: expected %0d, actual %0d",
                   want.period_counts, out_item_o.period_counts);
        end
      end
      out_ready_i <= !roll_pct(receiver_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ramped_step_pulse_generator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_command(rspg_pkg::op_e op, int unsigned idx, int unsigned hz);
    rspg_pkg::in_item_t cmd;
    cmd.opcode      = op;
    cmd.table_index = idx[rspg_pkg::TABLE_AW-1:0];
    cmd.table_hz    = hz[rspg_pkg::HZ_W-1:0];
    if (op == rspg_pkg::OP_LOAD) entry_loaded[idx] = 1'b1;
    pending_commands.push_back(cmd);
  endfunction

  // Table rate that mostly gives periods of a few dozen counts, with some zero and wild values.
  function automatic int unsigned pick_rate(int unsigned presc);
    int unsigned base;
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    r    = $urandom_range(99);
    base = rspg_pkg::BASE_CLOCK_HZ / presc;
    lo   = base / 40;
    hi   = base / 2;
    if (lo < 1) lo = 1;
    if (hi > 65535) hi = 65535;
    if (lo > hi) lo = hi;
    if (r < 3) return 0;
    if (r < 12) return $urandom_range(65535);
    return $urandom_range(hi, lo);
  endfunction

  // Wait until every command is accepted and every prediction is met, then let the block settle.
  task automatic settle();
    while (pending_commands.size() != 0 || in_valid_i || predicted_pulses.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_reg(rspg_pkg::cfg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      rspg_pkg::CFG_PRESCALER: reg_prescaler = val;
      rspg_pkg::CFG_START_HZ:  reg_start_hz = val;
      rspg_pkg::CFG_RAMP_LEN:  reg_ramp_len = val[10:0];
      default:                 reg_stop_count = val;
    endcase
  endtask

  // Program all registers in an idle gap and select the idling pattern of the next phase.
  task automatic begin_phase(int unsigned presc, int unsigned start, int unsigned len,
                             int unsigned stop, int unsigned mode);
    settle();
    program_reg(rspg_pkg::CFG_PRESCALER, presc[15:0]);
    program_reg(rspg_pkg::CFG_START_HZ, start[15:0]);
    program_reg(rspg_pkg::CFG_RAMP_LEN, len[15:0]);
    program_reg(rspg_pkg::CFG_STOP_CNT, stop[15:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sender_idle_pct    = (mode == 1) ? 53 : (mode == 3) ? 28 : 0;
    receiver_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 28 : 0;
  endtask

  // One random phase: fill every table entry the ramp can reach, start, then mostly ticks.
  task automatic random_phase(int unsigned presc, int unsigned start, int unsigned len,
                              int unsigned stop, int unsigned mode, int unsigned count);
    int unsigned reach;
    int unsigned r;
    begin_phase(presc, start, len, stop, mode);
    reach = (len - 2 < stop) ? len - 2 : stop;
    for (int unsigned i = 1; i <= reach; i++)
      if (!entry_loaded[i]) queue_command(rspg_pkg::OP_LOAD, i, pick_rate(presc));
    queue_command(rspg_pkg::OP_START, $urandom_range(1023), $urandom_range(65535));
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 78)
        queue_command(rspg_pkg::OP_TICK, $urandom_range(1023), $urandom_range(65535));
      else if (r < 83)
        queue_command(rspg_pkg::OP_START, $urandom_range(1023), $urandom_range(65535));
      else if (r < 87)
        queue_command(rspg_pkg::OP_STOP, $urandom_range(1023), $urandom_range(65535));
      else
        queue_command(rspg_pkg::OP_LOAD, $urandom_range(1023), pick_rate(presc));
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    for (int i = 0; i < rspg_pkg::TABLE_DEPTH; i++) begin
      gen_table[i]    = '0;
      entry_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Slowest rate: the period saturates, so no step is reached; covers stop and idle ticks.
    begin_phase(1, 1, 1024, 3, 0);
    queue_command(rspg_pkg::OP_LOAD, 1023, 65535);
    queue_command(rspg_pkg::OP_LOAD, 0, 0);
    queue_command(rspg_pkg::OP_LOAD, 1, 65535);
    queue_command(rspg_pkg::OP_LOAD, 2, 65535);
    queue_command(rspg_pkg::OP_LOAD, 3, 0);
    queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_START, 0, 0);
    queue_command(rspg_pkg::OP_TICK, 1023, 65535);
    queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_STOP, 0, 0);
    queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_START, 0, 0);
    queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_STOP, 0, 0);

    // Fastest rate: a step on every tick, a zero table entry, then the stop count.
    begin_phase(65535, 65535, 1024, 3, 0);
    queue_command(rspg_pkg::OP_START, 0, 0);
    repeat (5) queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_START, 0, 0);
    queue_command(rspg_pkg::OP_TICK, 0, 0);
    queue_command(rspg_pkg::OP_STOP, 0, 0);

    random_phase(1000, 5000, 1024, 40, 1, 165);
    random_phase(36000, 200, 64, 65535, 2, 165);
    random_phase(65535, 65535, 2, 65535, 3, 165);
    random_phase(5000, 1000, 300, 1, 0, 165);
    random_phase(2000, 3000, 20, 25, 3, 165);

    settle();
    if (mismatch_count == 0) begin
      $display("ramped_step_pulse_generator verification clean");
    end else begin
      $display("ramped_step_pulse_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== ramped_step_pulse_generator.f =====
+incdir+design
design/rspg_pkg.sv
design/rspg_ramp_table.sv
design/rspg_rate_div.sv
design/ramped_step_pulse_generator.sv
bench/ramped_step_pulse_generator_test.sv
